### rtl/wehr_pkg.sv
// shared types, sizes and codes for the warning event history ring
package wehr_pkg;

    // ring geometry
    localparam int CAPACITY = 16;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;

    // field widths
    localparam int REQ_W  = 2;
    localparam int TICK_W = 32;
    localparam int MASK_W = 8;
    localparam int SESS_W = 16;
    localparam int IDX_W  = 8;
    localparam int EV_W   = 2;
    localparam int TOT_W  = 32;
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    // event codes of a record
    typedef enum logic [EV_W-1:0] {
        EV_STARTED = 2'd0,
        EV_CLEARED = 2'd1,
        EV_CHANGED = 2'd2
    } t_event;

    // one stored record
    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [MASK_W-1:0] mask;
        t_event            event_code;
        logic [SESS_W-1:0] session;
    } t_record;

    localparam int REC_W = $bits(t_record);

    // ring memory access for one transaction
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        t_record          wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } t_mem_req;

    // decoded result held between the core and the output register
    typedef struct packed {
        logic              ok;
        logic              use_ram;
        t_record           rec;
        logic [CNT_W-1:0]  stored_count;
        logic [TOT_W-1:0]  overwritten_total;
        logic [TOT_W-1:0]  event_total;
        logic [MASK_W-1:0] active_mask;
    } t_stage;

endpackage

### rtl/wehr_ifs.sv
// request and response channel interfaces of the warning event history ring

// request channel
interface wehr_req_if;
    logic                            valid;
    logic                            ready;
    logic [wehr_pkg::REQ_W-1:0]      req_type;
    logic [wehr_pkg::TICK_W-1:0]     tick_ms;
    logic [wehr_pkg::MASK_W-1:0]     warn_bits;
    logic [wehr_pkg::SESS_W-1:0]     sess_tag;
    logic [wehr_pkg::IDX_W-1:0]      read_index;

    modport source (
        output valid, req_type, tick_ms, warn_bits, sess_tag, read_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, tick_ms, warn_bits, sess_tag, read_index,
        output ready
    );
endinterface

// response channel
interface wehr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [wehr_pkg::TICK_W-1:0]     rec_tick;
    logic [wehr_pkg::MASK_W-1:0]     rec_mask;
    logic [wehr_pkg::EV_W-1:0]       rec_event;
    logic [wehr_pkg::SESS_W-1:0]     rec_session;
    logic [wehr_pkg::CNT_W-1:0]      stored_count;
    logic [wehr_pkg::TOT_W-1:0]      overwritten_total;
    logic [wehr_pkg::TOT_W-1:0]      event_total;
    logic [wehr_pkg::MASK_W-1:0]     active_mask;

    modport source (
        output valid, ok, rec_tick, rec_mask, rec_event, rec_session, stored_count,
               overwritten_total, event_total, active_mask,
        input  ready
    );
    modport sink (
        input  valid, ok, rec_tick, rec_mask, rec_event, rec_session, stored_count,
               overwritten_total, event_total, active_mask,
        output ready
    );
endinterface

### rtl/wehr_ram.sv
// generic single write port, single read port ram with registered read data
module wehr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 58
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/wehr_core.sv
// request decode, ring pointers, counters and session tracking
module wehr_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [wehr_pkg::REQ_W-1:0]  i_req_type,
    input  logic [wehr_pkg::TICK_W-1:0] i_tick_ms,
    input  logic [wehr_pkg::MASK_W-1:0] i_warn_bits,
    input  logic [wehr_pkg::SESS_W-1:0] i_sess_tag,
    input  logic [wehr_pkg::IDX_W-1:0]  i_read_index,
    output wehr_pkg::t_mem_req          o_mem,
    output wehr_pkg::t_stage            o_stage
);

    logic [wehr_pkg::PTR_W-1:0]  r_wp,           n_wp;
    logic [wehr_pkg::CNT_W-1:0]  r_held,         n_held;
    logic [wehr_pkg::TOT_W-1:0]  r_lost,         n_lost;
    logic [wehr_pkg::TOT_W-1:0]  r_logged,       n_logged;
    logic [wehr_pkg::MASK_W-1:0] r_last_mask,    n_last_mask;
    logic [wehr_pkg::SESS_W-1:0] r_open_session, n_open_session;

    logic [wehr_pkg::SUM_W-1:0]  oldest_sum;
    logic [wehr_pkg::SUM_W-1:0]  oldest;
    logic [wehr_pkg::SUM_W-1:0]  addr_sum;
    logic [wehr_pkg::SUM_W-1:0]  addr_wrap;
    logic                        in_range;

    // oldest slot and physical address of the requested logical index
    always_comb begin
        oldest_sum = wehr_pkg::SUM_W'(r_wp) + wehr_pkg::SUM_W'(wehr_pkg::CAPACITY)
                     - wehr_pkg::SUM_W'(r_held);
        oldest     = (oldest_sum >= wehr_pkg::SUM_W'(wehr_pkg::CAPACITY))
                     ? oldest_sum - wehr_pkg::SUM_W'(wehr_pkg::CAPACITY) : oldest_sum;
        addr_sum   = oldest + wehr_pkg::SUM_W'(wehr_pkg::CNT_W'(i_read_index));
        addr_wrap  = (addr_sum >= wehr_pkg::SUM_W'(wehr_pkg::CAPACITY))
                     ? addr_sum - wehr_pkg::SUM_W'(wehr_pkg::CAPACITY) : addr_sum;
        in_range   = wehr_pkg::CMP_W'(i_read_index) < wehr_pkg::CMP_W'(r_held);
    end

    // next state, memory access and result of the transaction
    always_comb begin
        n_wp           = r_wp;
        n_held         = r_held;
        n_lost         = r_lost;
        n_logged       = r_logged;
        n_last_mask    = r_last_mask;
        n_open_session = r_open_session;
        o_mem          = '0;
        o_stage        = '0;
        o_mem.rd_addr  = addr_wrap[wehr_pkg::PTR_W-1:0];

        if (i_fire) begin
            unique case (wehr_pkg::t_req'(i_req_type))
                wehr_pkg::REQ_SAMPLE: begin
                    if (i_warn_bits != r_last_mask) begin
                        o_stage.ok       = 1'b1;
                        o_stage.rec.tick = i_tick_ms;
                        o_stage.rec.mask = i_warn_bits;
                        if (r_last_mask == '0) begin
                            o_stage.rec.event_code = wehr_pkg::EV_STARTED;
                            o_stage.rec.session    = i_sess_tag;
                            n_open_session         = i_sess_tag;
                        end else if (i_warn_bits == '0) begin
                            o_stage.rec.event_code = wehr_pkg::EV_CLEARED;
                            o_stage.rec.session    = r_open_session;
                            n_open_session         = '0;
                        end else begin
                            o_stage.rec.event_code = wehr_pkg::EV_CHANGED;
                            o_stage.rec.session    = i_sess_tag;
                            n_open_session         = i_sess_tag;
                        end
                        o_mem.wr_en   = 1'b1;
                        o_mem.wr_addr = r_wp;
                        o_mem.wr_data = o_stage.rec;
                        n_wp = (r_wp == wehr_pkg::PTR_W'(wehr_pkg::CAPACITY - 1))
                               ? '0 : r_wp + 1'b1;
                        // full ring: the oldest record is lost
                        if (r_held < wehr_pkg::CNT_W'(wehr_pkg::CAPACITY)) begin
                            n_held = r_held + 1'b1;
                        end else if (r_lost != '1) begin
                            n_lost = r_lost + 1'b1;
                        end
                        if (r_logged != '1) begin
                            n_logged = r_logged + 1'b1;
                        end
                        n_last_mask = i_warn_bits;
                    end
                end
                wehr_pkg::REQ_READ: begin
                    if (in_range) begin
                        o_stage.ok      = 1'b1;
                        o_stage.use_ram = 1'b1;
                        o_mem.rd_en     = 1'b1;
                    end
                end
                wehr_pkg::REQ_CLEAR: begin
                    o_stage.ok     = 1'b1;
                    n_held         = '0;
                    n_wp           = '0;
                    n_last_mask    = i_warn_bits;
                    n_open_session = (i_warn_bits == '0) ? '0 : i_sess_tag;
                end
                default: begin
                end
            endcase
        end

        o_stage.stored_count      = n_held;
        o_stage.overwritten_total = n_lost;
        o_stage.event_total       = n_logged;
        o_stage.active_mask       = n_last_mask;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp           <= '0;
            r_held         <= '0;
            r_lost         <= '0;
            r_logged       <= '0;
            r_last_mask    <= '0;
            r_open_session <= '0;
        end else begin
            r_wp           <= n_wp;
            r_held         <= n_held;
            r_lost         <= n_lost;
            r_logged       <= n_logged;
            r_last_mask    <= n_last_mask;
            r_open_session <= n_open_session;
        end
    end

`ifndef ASSERT_OFF
    // fill level never passes the ring size
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= wehr_pkg::CNT_W'(wehr_pkg::CAPACITY))
        else $error("held count above capacity");

    // until the ring wraps, the write pointer equals the fill level
    a_wp_tracks_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != wehr_pkg::CNT_W'(wehr_pkg::CAPACITY))
        |-> (wehr_pkg::CNT_W'(r_wp) == r_held))
        else $error("write pointer out of step with fill level");

    // records held never exceed records ever logged
    a_logged_covers_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wehr_pkg::TOT_W'(r_held) <= r_logged)
        else $error("held count above logged total");
`endif

endmodule

### rtl/warning_event_history_ring.sv
// warning event history ring, top level: request decode, ring ram, output register
// a result passes the stage register and is then offered from the output register
// one request per cycle unless stalled; the ring ram takes one write or one read a cycle
// ready drops only while both stages hold work and the response is not taken
// reset (i_rst_n low, synchronous) empties the ring, zeroes both totals, mask and session
// ring contents are not cleared; only entries written since reset or clear are read
module warning_event_history_ring (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wehr_req_if.sink    i_req,
    wehr_rsp_if.source  o_rsp
);

    logic                        fire_in;
    logic                        s1_go;
    wehr_pkg::t_mem_req          mem;
    wehr_pkg::t_stage            stage;
    logic [wehr_pkg::REC_W-1:0]  rd_data;
    wehr_pkg::t_record           rd_rec;

    logic                        r_s1_valid, n_s1_valid;
    wehr_pkg::t_stage            r_s1;
    logic                        r_out_valid, n_out_valid;
    wehr_pkg::t_stage            r_out;
    wehr_pkg::t_stage            n_out;

    // request handshake
    assign s1_go       = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_go;
    assign fire_in     = i_req.valid && i_req.ready;

    // decode and state update
    wehr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire_in),
        .i_req_type    (i_req.req_type),
        .i_tick_ms     (i_req.tick_ms),
        .i_warn_bits   (i_req.warn_bits),
        .i_sess_tag    (i_req.sess_tag),
        .i_read_index  (i_req.read_index),
        .o_mem         (mem),
        .o_stage       (stage)
    );

    // record ring
    wehr_ram #(
        .DEPTH (wehr_pkg::CAPACITY),
        .WIDTH (wehr_pkg::REC_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_rec = wehr_pkg::t_record'(rd_data);

    // stage and output valid flags, read data merged into the response
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (fire_in) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_go) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        n_out = r_s1;
        if (r_s1.use_ram) begin
            n_out.rec = rd_rec;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (fire_in) begin
            r_s1 <= stage;
        end
        if (s1_go) begin
            r_out <= n_out;
        end
    end

    // response channel
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.ok                = r_out.ok;
    assign o_rsp.rec_tick          = r_out.rec.tick;
    assign o_rsp.rec_mask          = r_out.rec.mask;
    assign o_rsp.rec_event         = r_out.rec.event_code;
    assign o_rsp.rec_session       = r_out.rec.session;
    assign o_rsp.stored_count      = r_out.stored_count;
    assign o_rsp.overwritten_total = r_out.overwritten_total;
    assign o_rsp.event_total       = r_out.event_total;
    assign o_rsp.active_mask       = r_out.active_mask;

endmodule

### sim/tb_top.sv
// testbench for the warning event history ring: directed and random requests, scoreboard
`timescale 1ns / 1ps

module tb_top;
    import wehr_pkg::*;

    // request code that the block ignores
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_ITEMS  = 400;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    // one response as seen on the response channel
    typedef struct packed {
        logic              ok;
        logic [TICK_W-1:0] tick;
        logic [MASK_W-1:0] mask;
        logic [EV_W-1:0]   ev;
        logic [SESS_W-1:0] session;
        logic [CNT_W-1:0]  stored;
        logic [TOT_W-1:0]  lost;
        logic [TOT_W-1:0]  logged;
        logic [MASK_W-1:0] active;
    } t_result;

    // ring predictor and response checker
    class history_scoreboard;
        t_record           ring_mem[CAPACITY];
        int unsigned       next_slot;
        int unsigned       held_records;
        logic [TOT_W-1:0]  lost_total;
        logic [TOT_W-1:0]  logged_total;
        logic [MASK_W-1:0] cur_mask;
        logic [SESS_W-1:0] cur_session;
        t_result           awaited_results[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       n_logged;
        int unsigned       n_hits;
        int unsigned       n_clears;

        function new();
            next_slot    = 0;
            held_records = 0;
            lost_total   = '0;
            logged_total = '0;
            cur_mask     = '0;
            cur_session  = '0;
            mismatches   = 0;
            checked      = 0;
            n_logged     = 0;
            n_hits       = 0;
            n_clears     = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        // work out the response of one accepted request
        function void log_request(logic [REQ_W-1:0] kind, logic [TICK_W-1:0] tick,
                                  logic [MASK_W-1:0] mask, logic [SESS_W-1:0] sess,
                                  logic [IDX_W-1:0] idx);
            t_result     r;
            t_record     rec;
            int unsigned oldest;
            r   = '0;
            rec = '0;
            case (kind)
                REQ_SAMPLE: begin
                    if (mask != cur_mask) begin
                        rec.tick = tick;
                        rec.mask = mask;
                        if (cur_mask == '0) begin
                            rec.event_code = EV_STARTED;
                            rec.session    = sess;
                            cur_session    = sess;
                        end else if (mask == '0) begin
                            // cleared keeps the session that was open
                            rec.event_code = EV_CLEARED;
                            rec.session    = cur_session;
                            cur_session    = '0;
                        end else begin
                            rec.event_code = EV_CHANGED;
                            rec.session    = sess;
                            cur_session    = sess;
                        end
                        ring_mem[next_slot] = rec;
                        next_slot = (next_slot + 1) % CAPACITY;
                        if (held_records < CAPACITY)
                            held_records++;
                        else if (lost_total != '1)
                            lost_total = lost_total + 1'b1;
                        if (logged_total != '1)
                            logged_total = logged_total + 1'b1;
                        cur_mask = mask;
                        r.ok     = 1'b1;
                        n_logged++;
                    end
                end
                REQ_READ: begin
                    if (idx < held_records) begin
                        oldest = (next_slot + CAPACITY - held_records) % CAPACITY;
                        rec    = ring_mem[(oldest + idx) % CAPACITY];
                        r.ok   = 1'b1;
                        n_hits++;
                    end
                end
                REQ_CLEAR: begin
                    held_records = 0;
                    next_slot    = 0;
                    cur_mask     = mask;
                    cur_session  = (mask == '0) ? '0 : sess;
                    r.ok         = 1'b1;
                    n_clears++;
                end
                default: ;
            endcase
            r.tick    = rec.tick;
            r.mask    = rec.mask;
            r.ev      = rec.event_code;
            r.session = rec.session;
            r.stored  = CNT_W'(held_records);
            r.lost    = lost_total;
            r.logged  = logged_total;
            r.active  = cur_mask;
            awaited_results.push_back(r);
        endfunction

        // compare one response with the oldest awaited one
        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with no request pending: ok=%0d tick=%h",
                             $realtime, got.ok, got.tick);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch on response %0d", $realtime, checked);
                    $display("  exp ok=%0d tick=%h mask=%h ev=%0d sess=%h",
                             want.ok, want.tick, want.mask, want.ev, want.session);
                    $display("      cnt=%0d lost=%0d tot=%0d act=%h",
                             want.stored, want.lost, want.logged, want.active);
                    $display("  got ok=%0d tick=%h mask=%h ev=%0d sess=%h",
                             got.ok, got.tick, got.mask, got.ev, got.session);
                    $display("      cnt=%0d lost=%0d tot=%0d act=%h",
                             got.stored, got.lost, got.logged, got.active);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic src_idle = 1'b0;
    logic rsp_idle = 1'b0;
    int unsigned quiet_cycles = 0;

    // mask and fill level as the sender sees them, to aim samples and reads
    logic [MASK_W-1:0] sent_mask = '0;
    int unsigned       sent_held = 0;

    history_scoreboard sb = new();

    wehr_req_if req_ch ();
    wehr_rsp_if rsp_ch ();

    warning_event_history_ring dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watch both channels, predict and check
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (req_ch.valid && req_ch.ready)
                sb.log_request(req_ch.req_type, req_ch.tick_ms, req_ch.warn_bits,
                               req_ch.sess_tag, req_ch.read_index);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result('{ok: rsp_ch.ok, tick: rsp_ch.rec_tick,
                                  mask: rsp_ch.rec_mask, ev: rsp_ch.rec_event,
                                  session: rsp_ch.rec_session, stored: rsp_ch.stored_count,
                                  lost: rsp_ch.overwritten_total,
                                  logged: rsp_ch.event_total, active: rsp_ch.active_mask});
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("warning_event_history_ring verification failed");
            $finish;
        end
    end

    // response side back-pressure in bursts
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_idle && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // drive one request and hold it until the block takes it
    task automatic issue(input logic [REQ_W-1:0] kind, input logic [TICK_W-1:0] tick,
                         input logic [MASK_W-1:0] mask, input logic [SESS_W-1:0] sess,
                         input logic [IDX_W-1:0] idx);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.tick_ms    <= tick;
        req_ch.warn_bits  <= mask;
        req_ch.sess_tag   <= sess;
        req_ch.read_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (kind == REQ_SAMPLE && mask != sent_mask) begin
            sent_mask = mask;
            if (sent_held < CAPACITY)
                sent_held++;
        end else if (kind == REQ_CLEAR) begin
            sent_mask = mask;
            sent_held = 0;
        end
    endtask

    // stimulus
    initial begin
        int unsigned       k;
        int unsigned       roll;
        int unsigned       pick;
        logic [TICK_W-1:0] tick_now;
        logic [MASK_W-1:0] mask;
        logic [IDX_W-1:0]  idx;
        logic [REQ_W-1:0]  kind;

        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_SAMPLE;
        req_ch.tick_ms    <= '0;
        req_ch.warn_bits  <= '0;
        req_ch.sess_tag   <= '0;
        req_ch.read_index <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, every event kind, field extremes
        issue(REQ_READ,   32'h0000_0010, 8'h00, 16'h0000, 8'd0);
        issue(REQ_SAMPLE, 32'h0000_0020, 8'h00, 16'h1111, 8'd0);
        issue(REQ_SAMPLE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF);
        issue(REQ_SAMPLE, 32'h0000_0030, 8'hFF, 16'h2222, 8'd0);
        issue(REQ_SAMPLE, 32'h0000_0000, 8'h01, 16'h0000, 8'd0);
        issue(REQ_SAMPLE, 32'h0000_0040, 8'h00, 16'h1234, 8'd0);
        issue(REQ_SAMPLE, 32'h0000_0050, 8'h80, 16'hABCD, 8'd0);
        // fill past capacity so the oldest record is overwritten
        for (k = 0; k < 13; k++)
            issue(REQ_SAMPLE, 32'h100 + k, MASK_W'(k + 2), SESS_W'($urandom()), 8'd0);
        issue(REQ_READ,   32'h0000_0060, 8'h00, 16'h0000, 8'd0);
        issue(REQ_READ,   32'h0000_0061, 8'h00, 16'h0000, 8'd15);
        issue(REQ_READ,   32'h0000_0062, 8'h00, 16'h0000, 8'd16);
        issue(REQ_READ,   32'h0000_0063, 8'h00, 16'h0000, 8'hFF);
        issue(REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF);
        // clear loads mask and session, then a cleared event reuses that session
        issue(REQ_CLEAR,  32'h0000_0070, 8'h5A, 16'h7777, 8'd0);
        issue(REQ_READ,   32'h0000_0071, 8'h00, 16'h0000, 8'd0);
        issue(REQ_SAMPLE, 32'h0000_0072, 8'h5A, 16'h3333, 8'd0);
        issue(REQ_SAMPLE, 32'h0000_0073, 8'h00, 16'h4444, 8'd0);
        issue(REQ_CLEAR,  32'h0000_0074, 8'h00, 16'hFFFF, 8'd0);

        // random: mostly mask changes and reads in range, some clears and noise
        tick_now = 32'h0000_1000;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0) begin
                src_idle = (k < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
                rsp_idle = (k < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            end
            tick_now = tick_now + $urandom_range(1, 3000);
            if ($urandom_range(0, 49) == 0)
                tick_now = $urandom();
            roll = $urandom_range(0, 99);
            mask = MASK_W'($urandom());
            idx  = IDX_W'($urandom());
            if (roll < 55 || roll >= 92) begin
                kind = REQ_SAMPLE;
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    mask = '0;
                else if (pick == 2)
                    mask = sent_mask;
                else if (pick == 3)
                    mask = sent_mask ^ MASK_W'(1 << $urandom_range(0, 7));
            end else if (roll < 88) begin
                kind = REQ_READ;
                if ($urandom_range(0, 7) != 0)
                    idx = IDX_W'($urandom_range(0, sent_held));
            end else if (roll < 90) begin
                kind = REQ_CLEAR;
                if ($urandom_range(0, 2) == 0)
                    mask = '0;
            end else begin
                kind = REQ_UNUSED;
            end
            issue(kind, tick_now, mask, SESS_W'($urandom()), idx);
        end
        req_ch.valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d responses: %0d records logged, %0d overwritten",
                 sb.checked, sb.n_logged, sb.lost_total);
        $display("reads in range %0d, clears %0d, mismatches %0d",
                 sb.n_hits, sb.n_clears, sb.mismatches);
        if (sb.mismatches == 0)
            $display("warning_event_history_ring verification clean");
        else
            $display("warning_event_history_ring verification failed");
        $finish;
    end

endmodule
